/* rtl/wsdf_pkg.sv */
// Shared types and constants for the websocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsdf_pkg;

  // Continuation opcode
  localparam logic [3:0] OP_CONT  = 4'h0;

  // Opcodes of control frames
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  localparam logic [15:0] STATUS_PROTOCOL = 16'd1002;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [3:0]  message_opcode;
    logic        frame_end;
    logic        message_end;
    logic [15:0] status_code;
  } res_t;

endpackage

/* rtl/wsdf_parse.sv */
// Frame parser: header, extended length, mask key and payload unmasking.
// Depends on wsdf_pkg; produces at most one result per accepted byte.
`timescale 1ns / 1ps

module wsdf_parse import wsdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  header_q, header_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] length_q, length_d;
  logic [63:0] count_q, count_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic        in_frag_q, in_frag_d;
  logic [3:0]  stored_op_q, stored_op_d;
  logic [15:0] close_st_q, close_st_d;
  logic [7:0]  mask_key_q [4];

  logic        hdr_close, hdr_ctrl;
  logic [3:0]  msg_op;
  logic [7:0]  unmasked;
  logic [63:0] count_inc;
  logic        key_we;

  assign hdr_close = header_q[3:0] == OP_CLOSE;
  assign hdr_ctrl  = (header_q[3:0] == OP_PING) || (header_q[3:0] == OP_PONG);
  assign msg_op    = hdr_close ? OP_CLOSE : stored_op_q;
  assign unmasked  = byte_i ^ mask_key_q[count_q[1:0]];
  assign count_inc = count_q + 64'd1;
  assign key_we    = accept_i && (phase_q == PH_MASK);

  always_comb begin
    phase_d     = phase_q;
    header_d    = header_q;
    ext_left_d  = ext_left_q;
    length_d    = length_q;
    count_d     = count_q;
    mask_idx_d  = mask_idx_q;
    in_frag_d   = in_frag_q;
    stored_op_d = stored_op_q;
    close_st_d  = close_st_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          header_d   = byte_i;
          close_st_d = '0;
          if ((byte_i[3:0] != OP_CLOSE) && (byte_i[3:0] != OP_PING)
              && (byte_i[3:0] != OP_PONG)) begin
            if (!byte_i[7]) begin
              if (!in_frag_q) begin
                stored_op_d = byte_i[3:0];
                in_frag_d   = 1'b1;
              end
            end else begin
              // final continuation of an open message keeps its opcode
              if (!((byte_i[3:0] == OP_CONT) && in_frag_q)) stored_op_d = byte_i[3:0];
              in_frag_d = 1'b0;
            end
          end
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          if (!byte_i[7]) begin
            // client frames must be masked
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_ERROR;
            res_o.status_code = STATUS_PROTOCOL;
            phase_d           = PH_HALT;
          end else begin
            mask_idx_d = '0;
            length_d   = '0;
            if (byte_i[6:0] == LEN_EXT16) begin
              ext_left_d = EXT16_BYTES;
              phase_d    = PH_EXTLEN;
            end else if (byte_i[6:0] == LEN_EXT64) begin
              ext_left_d = EXT64_BYTES;
              phase_d    = PH_EXTLEN;
            end else begin
              length_d = {57'd0, byte_i[6:0]};
              phase_d  = PH_MASK;
            end
          end
        end
        PH_EXTLEN: begin
          length_d   = {length_q[55:0], byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_d == 4'd0) phase_d = PH_MASK;
        end
        PH_MASK: begin
          if (mask_idx_q != 2'd3) begin
            mask_idx_d = mask_idx_q + 2'd1;
          end else begin
            mask_idx_d = '0;
            count_d    = '0;
            if (length_q != 64'd0) begin
              phase_d = PH_PAYLOAD;
            end else if (hdr_ctrl) begin
              phase_d = PH_HDR0;
            end else begin
              res_valid_o          = 1'b1;
              res_o.kind           = KIND_EMPTY;
              res_o.message_opcode = msg_op;
              res_o.frame_end      = 1'b1;
              if (hdr_close) begin
                // empty close carries no status
                phase_d = PH_HALT;
              end else begin
                res_o.message_end = header_q[7];
                phase_d           = PH_HDR0;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (count_q == 64'd0) close_st_d = {unmasked, 8'd0};
          else if (count_q == 64'd1) close_st_d = {close_st_q[15:8], unmasked};
          count_d = count_inc;
          if (!hdr_ctrl) begin
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_DATA;
            res_o.payload_byte   = unmasked;
            res_o.message_opcode = msg_op;
          end
          if (count_inc == length_q) begin
            if (hdr_ctrl) begin
              phase_d = PH_HDR0;
            end else if (hdr_close) begin
              res_o.frame_end = 1'b1;
              if (length_q >= 64'd2) res_o.status_code = close_st_d;
              phase_d = PH_HALT;
            end else begin
              res_o.frame_end   = 1'b1;
              res_o.message_end = header_q[7];
              phase_d           = PH_HDR0;
            end
          end
        end
        default: ;  // halted: bytes are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      header_q    <= '0;
      ext_left_q  <= '0;
      length_q    <= '0;
      count_q     <= '0;
      mask_idx_q  <= '0;
      in_frag_q   <= 1'b0;
      stored_op_q <= '0;
      close_st_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      header_q    <= header_d;
      ext_left_q  <= ext_left_d;
      length_q    <= length_d;
      count_q     <= count_d;
      mask_idx_q  <= mask_idx_d;
      in_frag_q   <= in_frag_d;
      stored_op_q <= stored_op_d;
      close_st_q  <= close_st_d;
    end
  end

  // mask key has no reset; written before any payload reads it
  always_ff @(posedge clk_i) begin
    if (key_we) mask_key_q[mask_idx_q] <= byte_i;
  end

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == KIND_ERROR)) |=> (phase_q == PH_HALT))
    else $error("protocol error did not halt the parser");

  a_close_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_end && (res_o.message_opcode == OP_CLOSE))
    |=> (phase_q == PH_HALT))
    else $error("close frame end did not halt the parser");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HALT) |-> !res_valid_o)
    else $error("result produced while halted");

  a_msg_end_needs_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.message_end) |-> res_o.frame_end)
    else $error("message end without frame end");

endmodule

/* rtl/wsdf_outreg.sv */
// Output register between the parser and the master stream port.
// Depends on wsdf_pkg for the result struct.
`timescale 1ns / 1ps

module wsdf_outreg import wsdf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic free_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // slot frees up in the same cycle the held result transfers
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* rtl/websocket_frame_deframer.sv */
// Top level of the websocket frame deframer: stream ports, parser, output register.
// Depends on wsdf_pkg, wsdf_parse and wsdf_outreg.
`timescale 1ns / 1ps

// Decodes a client-to-server WebSocket byte stream: one byte per cycle in, at most
// one result per byte out. Each byte is handled in the cycle it transfers; its
// result lands in a single output register, and a new byte is taken whenever that
// register is empty or its result is transferring in the same cycle, so the
// sustained rate is one byte per clock while the master port is ready, and a byte's
// result appears in the next cycle. Payload bytes of data and close frames come out
// unmasked; tlast marks the last result of a frame. A close frame end or an unmasked
// frame halts the block until reset; later bytes are still taken and dropped.

module websocket_frame_deframer import wsdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] stream_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] payload_byte, [11:8] message_opcode,
                                        // [27:12] status_code, [31:28] zero
  output logic        m_axis_tlast_o,   // frame_end
  output logic [2:0]  m_axis_tuser_o    // [1:0] kind, [2] message_end
);

  logic accept;
  logic res_valid;
  logic free;
  res_t res;
  res_t out_res;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  wsdf_parse u_parse (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsdf_outreg u_outreg (
    .clk_i,
    .rst_ni,
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready_i),
    .free_o  (free),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {4'd0, out_res.status_code, out_res.message_opcode,
                           out_res.payload_byte};
  assign m_axis_tlast_o = out_res.frame_end;
  assign m_axis_tuser_o = {out_res.message_end, out_res.kind};

endmodule
